// ===== rtl/flp_pkg.sv =====
// Five-button lamp panel: shared types and constants.
// Holds button-lane event flags, the lamp state record and fixed encodings.
// No dependencies.
package flp_pkg;

    localparam int NUM_BTN     = 5;
    localparam int COLOR_MODES = 4;
    localparam int LAMP_MODES  = 2;
    localparam int SCREENS     = 2;

    localparam int BTN_UP    = 0;
    localparam int BTN_DOWN  = 1;
    localparam int BTN_COLOR = 2;
    localparam int BTN_POWER = 3;
    localparam int BTN_MENU  = 4;

    localparam logic [3:0]  CFG_PRESS_MIN = 4'd0;
    localparam logic [3:0]  CFG_HOLD      = 4'd1;

    localparam logic [7:0]  PRESS_MIN_RST = 8'd3;
    localparam logic [7:0]  HOLD_RST      = 8'd25;
    localparam logic [7:0]  CNT_MAX       = 8'd255;

    localparam logic [6:0]  BRIGHT_MAX    = 7'd100;
    localparam logic [19:0] TIMER_STEP    = 20'd60;
    localparam logic [20:0] TIMER_MAX     = 21'd1048575;

    localparam logic [1:0]  SCR_MAIN      = 2'd0;
    localparam logic [1:0]  SCR_SET       = 2'd1;
    localparam logic [1:0]  MODE_SWITCH   = 2'd0;
    localparam logic [1:0]  MODE_TIMED    = 2'd1;

    typedef struct packed {
        logic short_rel;
        logic long_rel;
        logic repeat_hit;
        logic hold_hit;
    } flp_event_t;

    typedef struct packed {
        logic [6:0]  bright;
        logic [19:0] timer_len;
        logic [31:0] start;
        logic [3:0]  color;
        logic        power;
        logic [1:0]  mode;
        logic [1:0]  screen;
    } flp_state_t;

endpackage

// ===== rtl/flp_btn_lane.sv =====
// Five-button lamp panel: one button lane.
// Holds the saturating hold counter and classifies presses into events.
// Depends on flp_pkg.
module flp_btn_lane
    import flp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       level,
    input  logic [7:0] press_min,
    input  logic [7:0] hold,
    output flp_event_t evt
);

    logic [7:0] cnt_reg;
    logic [7:0] cnt_next;
    logic       stepped;

    always_comb
    begin
        stepped  = level && (cnt_reg != CNT_MAX);
        if (!level)
        begin
            cnt_next = 8'd0;
        end
        else if (stepped)
        begin
            cnt_next = cnt_reg + 8'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
        evt.short_rel  = !level && (cnt_reg > press_min) && (cnt_reg < hold);
        evt.long_rel   = !level && (cnt_reg > press_min);
        evt.repeat_hit = level && (cnt_next > hold);
        evt.hold_hit   = stepped && (cnt_next == hold);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 8'd0;
        end
        else if (advance)
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/flp_merge.sv =====
// Five-button lamp panel: merging stage.
// Applies the lane events in button order to the lamp state and holds it.
// Depends on flp_pkg.
module flp_merge
    import flp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  flp_event_t [NUM_BTN-1:0] evt,
    input  logic [31:0]         now_time,
    output flp_state_t          state_next
);

    flp_state_t state_reg;
    flp_state_t s;
    logic       up_act;
    logic       down_act;
    logic [20:0] t_sum;
    logic [4:0] c_inc;
    logic [2:0] m_inc;
    logic [2:0] sc_inc;

    always_comb
    begin
        s        = state_reg;
        up_act   = evt[BTN_UP].short_rel || evt[BTN_UP].repeat_hit;
        down_act = evt[BTN_DOWN].short_rel || evt[BTN_DOWN].repeat_hit;
        t_sum    = {1'b0, s.timer_len} + {1'b0, TIMER_STEP};

        if (up_act)
        begin
            if (s.screen == SCR_MAIN)
            begin
                if (s.bright < BRIGHT_MAX)
                begin
                    s.bright = s.bright + 7'd1;
                end
            end
            else if (s.screen == SCR_SET)
            begin
                s.start     = now_time;
                s.timer_len = (t_sum > TIMER_MAX) ? TIMER_MAX[19:0] : t_sum[19:0];
            end
        end

        if (down_act)
        begin
            if (s.screen == SCR_MAIN)
            begin
                if (s.bright != 7'd0)
                begin
                    s.bright = s.bright - 7'd1;
                end
            end
            else if (s.screen == SCR_SET)
            begin
                if (s.timer_len >= TIMER_STEP)
                begin
                    s.start     = now_time;
                    s.timer_len = s.timer_len - TIMER_STEP;
                end
            end
        end

        c_inc = {1'b0, s.color} + 5'd1;
        if (evt[BTN_COLOR].short_rel && (s.screen == SCR_MAIN))
        begin
            s.color = (c_inc >= 5'(COLOR_MODES)) ? 4'd0 : c_inc[3:0];
        end

        if (evt[BTN_POWER].long_rel)
        begin
            if (s.mode == MODE_SWITCH)
            begin
                s.power = !s.power;
            end
            else if (s.mode == MODE_TIMED)
            begin
                s.power = !s.power;
                s.start = now_time;
            end
        end

        sc_inc = {1'b0, s.screen} + 3'd1;
        m_inc  = {1'b0, s.mode} + 3'd1;
        if (evt[BTN_MENU].hold_hit)
        begin
            s.screen = (sc_inc >= 3'(SCREENS)) ? 2'd0 : sc_inc[1:0];
        end
        else if (evt[BTN_MENU].short_rel && (s.screen == SCR_MAIN))
        begin
            s.mode = (m_inc >= 3'(LAMP_MODES)) ? 2'd0 : m_inc[1:0];
            if (s.mode == MODE_TIMED)
            begin
                s.start = now_time;
            end
        end

        state_next = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/five_button_lamp_panel_core.sv =====
// Five-button lamp panel core: top level.
// Instantiates five flp_btn_lane counters and flp_merge; holds config and output buffer.
// Depends on flp_pkg, flp_btn_lane, flp_merge.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------------
//   in      | in_valid / in_stall    | btn_up..btn_menu, now_time
//   out     | out_valid / out_stall  | brightness, off_timer, timer_start,
//           |                        | color_sel, light_on, lamp_mode, screen
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One scan tick per clock while in_stall is low; each accepted result is registered into
// the output register (the skid while that is held) via combinational lane/merge logic.
// A two-entry output buffer (output register plus skid) keeps input flowing
// for one extra transaction while out_stall is high; in_stall rises when the skid is full.
// Reset clears counters, lamp state and buffer valids; config returns to 3 and 25.
module five_button_lamp_panel_core
    import flp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        btn_up,
    input  logic        btn_down,
    input  logic        btn_color,
    input  logic        btn_power,
    input  logic        btn_menu,
    input  logic [31:0] now_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  brightness,
    output logic [19:0] off_timer,
    output logic [31:0] timer_start,
    output logic [3:0]  color_sel,
    output logic        light_on,
    output logic [1:0]  lamp_mode,
    output logic [1:0]  screen,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0]  press_min_reg;
    logic [7:0]  hold_reg;
    logic        accept;
    logic        take;
    logic [NUM_BTN-1:0] levels;
    flp_event_t [NUM_BTN-1:0] evt;
    flp_state_t  state_next;
    flp_state_t  out_reg;
    flp_state_t  skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign take      = out_valid_reg && !out_stall;
    assign levels    = {btn_menu, btn_power, btn_color, btn_down, btn_up};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_min_reg <= PRESS_MIN_RST;
            hold_reg      <= HOLD_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PRESS_MIN: press_min_reg <= cfg_data;
                CFG_HOLD:      hold_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < NUM_BTN; i++)
        begin : g_lane
            flp_btn_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (accept),
                .level     (levels[i]),
                .press_min (press_min_reg),
                .hold      (hold_reg),
                .evt       (evt[i])
            );
        end
    endgenerate

    flp_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (accept),
        .evt        (evt),
        .now_time   (now_time),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= state_next;
            end
        end
        else if (accept)
        begin
            skid_reg <= state_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign brightness  = out_reg.bright;
    assign off_timer   = out_reg.timer_len;
    assign timer_start = out_reg.start;
    assign color_sel   = out_reg.color;
    assign light_on    = out_reg.power;
    assign lamp_mode   = out_reg.mode;
    assign screen      = out_reg.screen;

endmodule
